### sv/rpn_stack_evaluator_core_defines.svh
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_core_defines
// Assertion macros used by the checker file of the evaluator.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_EVALUATOR_CORE_DEFINES_SVH
`define RPN_STACK_EVALUATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst is high.
`define RSE_CHECK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst is high.
`define RSE_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg
// Field widths, request, operator and status codes, and the control structs
// shared by the evaluator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rse_pkg;

  localparam int NUM_W = 32;
  localparam int REQ_W = 2;
  localparam int OP_W  = 3;
  localparam int ST_W  = 3;

  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_OP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_END  = 2'd2;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_REM = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_FEW     = 3'd1;
  localparam logic [ST_W-1:0] ST_DIV0    = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_ONE = 3'd4;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  typedef struct packed {
    logic            start;
    logic [OP_W-1:0] op;
  } alu_cmd_t;

endpackage

`default_nettype wire

### sv/rpn_stack_evaluator_core.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_core
// Postfix integer expression evaluator on a shifting operand stack.
// ----------------------------------------------------------------------------
// Tokens arrive on the req channel; only an end token produces a transfer on
// the rsp channel. A push, add, subtract, end, ignored or erroring token is
// handled in the cycle it is taken. Multiply, divide and remainder run in the
// shared iterative unit, one product or quotient bit per cycle, then a sign
// fix; the unit then signals done and the result is written back to the stack
// in that cycle; no token is taken while it runs. A finished result waits in
// the output register, and tokens other than end keep flowing while it waits.
// The stack is a row of STACK_DEPTH cells that shift down on push and up on
// pop, so the top two values always sit in the first two cells.
`default_nettype none

module rpn_stack_evaluator_core import rse_pkg::*; #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  logic [REQ_W-1:0]        req_type,
  input  logic signed [NUM_W-1:0] number,
  input  logic [OP_W-1:0]         op_code,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output logic signed [NUM_W-1:0] value,
  output logic [ST_W-1:0]         status
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic                   state;
  logic                   state_next;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [ST_W-1:0]        err;
  logic [ST_W-1:0]        err_next;

  logic [VALUE_WIDTH-1:0] cell_data [STACK_DEPTH];
  cell_ctl_t              ctl;
  alu_cmd_t               alu_cmd;
  logic                   alu_done;
  logic [VALUE_WIDTH-1:0] alu_result;
  logic [VALUE_WIDTH-1:0] top_a;
  logic [VALUE_WIDTH-1:0] top_b;
  logic [VALUE_WIDTH-1:0] pop_value;
  logic                   req_fire;
  logic                   no_err;
  logic                   emit;

  assign top_b     = cell_data[0];
  assign top_a     = cell_data[1];
  assign no_err    = (err == ST_OK);
  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready || req_type != REQ_END);
  assign req_fire  = req_valid && req_ready;
  assign pop_value = (state == S_BUSY) ? alu_result
                   : (op_code == OP_SUB) ? (top_a - top_b) : (top_a + top_b);

  genvar i;
  generate
    for (i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] prev_d;
      logic [VALUE_WIDTH-1:0] next_d;
      if (i == 0) begin : g_top
        assign prev_d = VALUE_WIDTH'(number);
        assign next_d = pop_value;
      end else if (i == STACK_DEPTH - 1) begin : g_bottom
        assign prev_d = cell_data[i-1];
        assign next_d = '0;
      end else begin : g_mid
        assign prev_d = cell_data[i-1];
        assign next_d = cell_data[i+1];
      end
      rse_cell #(.W(VALUE_WIDTH)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .from_prev (prev_d),
        .from_next (next_d),
        .data      (cell_data[i])
      );
    end
  endgenerate

  rse_alu #(.W(VALUE_WIDTH)) u_alu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (alu_cmd),
    .a      (top_a),
    .b      (top_b),
    .done   (alu_done),
    .result (alu_result)
  );

  always_comb begin
    ctl        = '0;
    alu_cmd    = '0;
    emit       = 1'b0;
    state_next = state;
    count_next = count;
    err_next   = err;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          case (req_type)
            REQ_PUSH: begin
              if (no_err) begin
                if (count == CNT_W'(STACK_DEPTH)) begin
                  err_next = ST_FULL;
                end else begin
                  ctl.push   = 1'b1;
                  count_next = count + CNT_W'(1);
                end
              end
            end
            REQ_OP: begin
              if (no_err && op_code <= OP_REM) begin
                if (count < CNT_W'(2)) begin
                  err_next = ST_FEW;
                end else begin
                  case (op_code)
                    OP_ADD, OP_SUB: begin
                      ctl.pop    = 1'b1;
                      count_next = count - CNT_W'(1);
                    end
                    OP_MUL: begin
                      alu_cmd.start = 1'b1;
                      alu_cmd.op    = op_code;
                      state_next    = S_BUSY;
                    end
                    OP_DIV, OP_REM: begin
                      if (top_b == '0) begin
                        err_next = ST_DIV0;
                      end else begin
                        alu_cmd.start = 1'b1;
                        alu_cmd.op    = op_code;
                        state_next    = S_BUSY;
                      end
                    end
                    default: ;
                  endcase
                end
              end
            end
            REQ_END: begin
              emit       = 1'b1;
              count_next = '0;
              err_next   = ST_OK;
            end
            default: ;
          endcase
        end
      end
      S_BUSY: begin
        if (alu_done) begin
          ctl.pop    = 1'b1;
          count_next = count - CNT_W'(1);
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      err       <= ST_OK;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      err   <= err_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (!no_err) begin
        value  <= '0;
        status <= err;
      end else if (count == CNT_W'(1)) begin
        value  <= NUM_W'(top_b);
        status <= ST_OK;
      end else begin
        value  <= '0;
        status <= ST_NOT_ONE;
      end
    end
  end

endmodule

`default_nettype wire

### sv/rse_cell.sv
// ----------------------------------------------------------------------------
// rse_cell
// One operand stack entry. Takes the entry above it on a push and the entry
// below it on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_cell import rse_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  cell_ctl_t    ctl,
  input  logic [W-1:0] from_prev,
  input  logic [W-1:0] from_next,
  output logic [W-1:0] data
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data <= from_prev;
    end else if (ctl.pop) begin
      data <= from_next;
    end
  end

endmodule

`default_nettype wire

### sv/rse_alu.sv
// ----------------------------------------------------------------------------
// rse_alu
// Iterative multiply, divide and remainder unit: shift-add multiply and
// restoring division on magnitudes, one bit per cycle, then a sign fix.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_alu import rse_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  alu_cmd_t     cmd,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] result
);

  localparam int CNT_W = $clog2(W + 1);

  logic             running;
  logic             finishing;
  logic [CNT_W-1:0] cnt;
  logic             is_mul;
  logic             want_rem;
  logic             neg;
  logic [W:0]       acc;
  logic [W-1:0]     sh_a;
  logic [W-1:0]     sh_b;

  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic [W:0]   rem_sh;
  logic [W:0]   diff;
  logic [W-1:0] addend;
  logic [W-1:0] mag_res;

  assign mag_a   = a[W-1] ? (~a + W'(1)) : a;
  assign mag_b   = b[W-1] ? (~b + W'(1)) : b;
  assign rem_sh  = {acc[W-1:0], sh_a[W-1]};
  assign diff    = rem_sh - {1'b0, sh_b};
  assign addend  = sh_b[0] ? sh_a : '0;
  assign mag_res = (is_mul || want_rem) ? acc[W-1:0] : sh_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      finishing <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        running   <= 1'b1;
        finishing <= 1'b0;
      end else if (running && cnt == CNT_W'(1)) begin
        running   <= 1'b0;
        finishing <= 1'b1;
      end else if (finishing) begin
        finishing <= 1'b0;
        done      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cnt      <= CNT_W'(W);
      is_mul   <= (cmd.op == OP_MUL);
      want_rem <= (cmd.op == OP_REM);
      acc      <= '0;
      if (cmd.op == OP_MUL) begin
        sh_a <= a;
        sh_b <= b;
        neg  <= 1'b0;
      end else begin
        sh_a <= mag_a;
        sh_b <= mag_b;
        neg  <= (cmd.op == OP_REM) ? a[W-1] : (a[W-1] ^ b[W-1]);
      end
    end else if (running) begin
      cnt <= cnt - CNT_W'(1);
      if (is_mul) begin
        acc  <= {1'b0, acc[W-1:0] + addend};
        sh_a <= {sh_a[W-2:0], 1'b0};
        sh_b <= {1'b0, sh_b[W-1:1]};
      end else begin
        acc  <= diff[W] ? rem_sh : diff;
        sh_a <= {sh_a[W-2:0], ~diff[W]};
      end
    end
    if (finishing) begin
      result <= neg ? (~mag_res + W'(1)) : mag_res;
    end
  end

endmodule

`default_nettype wire

### sv/rse_checker.sv
// ----------------------------------------------------------------------------
// rse_checker
// Port-level assertions for the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rpn_stack_evaluator_core_defines.svh"

module rse_checker import rse_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    req_valid,
  input logic                    req_ready,
  input logic [REQ_W-1:0]        req_type,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic signed [NUM_W-1:0] value,
  input logic [ST_W-1:0]         status
);

  `RSE_CHECK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(value) && $stable(status), "rsp changed while stalled")
  `RSE_CHECK_IMPL(a_err_zero, rsp_valid && status != ST_OK, value == '0, "nonzero value with error status")
  `RSE_CHECK_IMPL(a_status_range, rsp_valid, status <= ST_NOT_ONE, "status code out of range")
  `RSE_CHECK_IMPL(a_rsp_cause, !rsp_valid ##1 rsp_valid, $past(req_valid && req_ready && req_type == REQ_END), "result without end token")

endmodule

bind rpn_stack_evaluator_core rse_checker u_rse_checker (.*);

`default_nettype wire
